FILE: sv/sle_pkg.sv
// shared constants, command codes and controller/datapath handoff types
package sle_pkg;

  localparam int SPRITE_ENTRIES = 64;
  localparam int MAX_PER_LINE   = 8;

  localparam int MEM_BYTES   = 256;
  localparam int ADDR_W      = 8;
  localparam int DATA_W      = 8;
  localparam int CMD_W       = 3;
  localparam int SLOT_W      = 6;
  localparam int SLOT_FIELDS = 8;
  localparam int HIT_W       = 4;
  localparam int HIT_MAX     = 15;

  localparam int ENTRY_W = (SPRITE_ENTRIES > 1) ? $clog2(SPRITE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_PER_LINE + 1);
  localparam int LIST_W  = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1;

  localparam int HEIGHT_SHORT = 7;
  localparam int HEIGHT_TALL  = 15;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_PTR  = 3'd0,
    CMD_WRITE    = 3'd1,
    CMD_READ     = 3'd2,
    CMD_READ_PTR = 3'd3,
    CMD_EVAL     = 3'd4
  } cmd_code_t;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic clr_en;
    logic start;
    logic scan_en;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_eval;
    logic scan_done;
  } dp_stat_t;

endpackage

FILE: sv/sle_in_if.sv
// command channel: cmd, value, line
interface sle_in_if;
  import sle_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] value;
  logic [DATA_W-1:0] line;

  modport source (output valid, cmd, value, line, input ready);
  modport sink   (input valid, cmd, value, line, output ready);
  modport mon    (input valid, ready, cmd, value, line);
endinterface

FILE: sv/sle_out_if.sv
// result channel: read byte, found list, overflow flag
interface sle_out_if;
  import sle_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [HIT_W-1:0]  hit_count;
  logic              overflow;
  logic [SLOT_W-1:0] slot_0;
  logic [SLOT_W-1:0] slot_1;
  logic [SLOT_W-1:0] slot_2;
  logic [SLOT_W-1:0] slot_3;
  logic [SLOT_W-1:0] slot_4;
  logic [SLOT_W-1:0] slot_5;
  logic [SLOT_W-1:0] slot_6;
  logic [SLOT_W-1:0] slot_7;

  modport source (output valid, read_data, hit_count, overflow,
                  slot_0, slot_1, slot_2, slot_3, slot_4, slot_5, slot_6, slot_7,
                  input ready);
  modport sink   (input valid, read_data, hit_count, overflow,
                  slot_0, slot_1, slot_2, slot_3, slot_4, slot_5, slot_6, slot_7,
                  output ready);
  modport mon    (input valid, ready, read_data, hit_count, overflow,
                  slot_0, slot_1, slot_2, slot_3, slot_4, slot_5, slot_6, slot_7);
endinterface

FILE: sv/sle_ctrl.sv
// control state machine: memory clear, command dispatch, scan, result handoff
module sle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  sle_pkg::dp_stat_t  stat,
  output sle_pkg::dp_cmd_t   cmd
);
  import sle_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.clr_en   = (state_r == ST_CLEAR);
    cmd.start    = accept;
    cmd.scan_en  = (state_r == ST_SCAN);
    cmd.load_out = (state_r == ST_DONE) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = stat.is_eval ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (stat.scan_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/sle_dp.sv
// datapath: attribute memory, byte pointer, scan compare, found list, result register
module sle_dp (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  sle_pkg::dp_cmd_t                                  cmd,
  output sle_pkg::dp_stat_t                                 stat,
  input  logic [sle_pkg::CMD_W-1:0]                         in_cmd,
  input  logic [sle_pkg::DATA_W-1:0]                        in_value,
  input  logic [sle_pkg::DATA_W-1:0]                        in_line,
  input  logic                                              cfg_wr_en,
  input  logic                                              cfg_wr_data,
  output logic [sle_pkg::DATA_W-1:0]                        out_read_data,
  output logic [sle_pkg::HIT_W-1:0]                         out_hit_count,
  output logic                                              out_overflow,
  output logic [sle_pkg::SLOT_FIELDS-1:0][sle_pkg::SLOT_W-1:0] out_slots
);
  import sle_pkg::*;

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [ENTRY_W-1:0] idx);
    return ADDR_W'({idx, 2'b00});
  endfunction

  logic [DATA_W-1:0] mem [MEM_BYTES];
  logic [DATA_W-1:0] mem_q_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [DATA_W-1:0] mem_wd;

  logic [ADDR_W-1:0]  ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]  clr_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [DATA_W-1:0]  line_r;
  logic               tall_r;
  logic [ENTRY_W-1:0] idx_r;
  slot_t              list_r [MAX_PER_LINE];
  logic [CNT_W-1:0]   count_r;
  logic               ovf_r;

  logic [DATA_W-1:0]  rd_data_r;
  logic [HIT_W-1:0]   hit_cnt_r;
  logic               ovf_out_r;
  slot_t [SLOT_FIELDS-1:0] slots_r, slots_nxt;

  logic               start_eval, start_write, start_read;
  logic               last_entry, list_full, hit, ovf_hit, keep_hit;
  logic [DATA_W:0]    top;
  logic [DATA_W+1:0]  bottom;
  logic [DATA_W-1:0]  rd_data_nxt;
  logic [HIT_W-1:0]   hit_cnt_nxt;

  assign start_eval  = cmd.start && (in_cmd == CMD_EVAL);
  assign start_write = cmd.start && (in_cmd == CMD_WRITE);
  assign start_read  = cmd.start && (in_cmd == CMD_READ);

  assign last_entry = (idx_r == ENTRY_W'(SPRITE_ENTRIES - 1));
  assign list_full  = (count_r >= CNT_W'(MAX_PER_LINE));

  // sprite covers rows top .. top+height, top is the stored y plus one
  assign top    = {1'b0, mem_q_r} + (DATA_W+1)'(1);
  assign bottom = {1'b0, top} + (tall_r ? (DATA_W+2)'(HEIGHT_TALL) : (DATA_W+2)'(HEIGHT_SHORT));
  assign hit    = ({1'b0, line_r} >= top) && ({2'b00, line_r} <= bottom);
  assign ovf_hit  = cmd.scan_en && hit && list_full;
  assign keep_hit = cmd.scan_en && hit && !list_full;

  always_comb begin
    stat.clr_last  = cmd.clr_en && (clr_r == ADDR_W'(MEM_BYTES - 1));
    stat.is_eval   = (in_cmd == CMD_EVAL);
    stat.scan_done = cmd.scan_en && (last_entry || ovf_hit);
  end

  // one write port shared by the clear sweep and byte writes
  always_comb begin
    mem_we = cmd.clr_en || start_write;
    mem_wa = cmd.clr_en ? clr_r : ptr_r;
    mem_wd = cmd.clr_en ? '0 : in_value;
    mem_re = start_read || start_eval || (cmd.scan_en && !last_entry);
    if (cmd.scan_en) mem_ra = entry_addr(idx_r + ENTRY_W'(1));
    else if (start_eval) mem_ra = entry_addr('0);
    else mem_ra = ptr_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q_r <= mem[mem_ra];
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.start && (in_cmd == CMD_SET_PTR)) ptr_nxt = in_value;
    else if (start_write) ptr_nxt = ptr_r + ADDR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      clr_r   <= '0;
      tall_r  <= 1'b0;
      count_r <= '0;
      ovf_r   <= 1'b0;
      for (int i = 0; i < MAX_PER_LINE; i++) list_r[i] <= '0;
    end else begin
      ptr_r <= ptr_nxt;
      if (cmd.clr_en) clr_r <= clr_r + ADDR_W'(1);
      if (cfg_wr_en) tall_r <= cfg_wr_data;
      if (ovf_hit) ovf_r <= 1'b1;
      if (start_eval) begin
        count_r <= '0;
        for (int i = 0; i < MAX_PER_LINE; i++) list_r[i] <= '0;
      end else if (keep_hit) begin
        list_r[count_r[LIST_W-1:0]] <= SLOT_W'(idx_r);
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cmd_r  <= in_cmd;
      line_r <= in_line;
    end
    if (start_eval) idx_r <= '0;
    else if (cmd.scan_en) idx_r <= idx_r + ENTRY_W'(1);
  end

  always_comb begin
    case (cmd_r)
      CMD_READ:     rd_data_nxt = mem_q_r;
      CMD_READ_PTR: rd_data_nxt = ptr_r;
      default:      rd_data_nxt = '0;
    endcase
    if (32'(count_r) > HIT_MAX) hit_cnt_nxt = HIT_W'(HIT_MAX);
    else hit_cnt_nxt = HIT_W'(count_r);
  end

  for (genvar k = 0; k < SLOT_FIELDS; k++) begin : g_slot
    if (k < MAX_PER_LINE) begin : g_used
      assign slots_nxt[k] = list_r[k];
    end else begin : g_unused
      assign slots_nxt[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rd_data_r <= rd_data_nxt;
      hit_cnt_r <= hit_cnt_nxt;
      ovf_out_r <= ovf_r;
      slots_r   <= slots_nxt;
    end
  end

  assign out_read_data = rd_data_r;
  assign out_hit_count = hit_cnt_r;
  assign out_overflow  = ovf_out_r;
  assign out_slots     = slots_r;

endmodule

FILE: sv/sprite_line_evaluation_unit.sv
// top level of the sprite line evaluation unit
//
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        cmd, value, line
//  out_ch   out  valid/ready        read_data, hit_count, overflow, slot_0..slot_7
//  cfg_     in   cfg_wr_en (write)  cfg_wr_data -> sprite_tall
//
// after reset the attribute memory is zeroed, one byte a cycle: in_ch.ready stays low
// until the clear sweep has written the last byte. set pointer, write, read and read
// pointer go from accept to the result state. evaluate line scans every entry, one per
// cycle through the single memory read port; it ends early on overflow.
// one result beat per command; a new command is taken while the last result is waiting,
// and finishing holds in place while out_ch is stalled.
module sprite_line_evaluation_unit (
  input  logic      clk,
  input  logic      rst_n,
  sle_in_if.sink    in_ch,
  sle_out_if.source out_ch,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);
  import sle_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic [SLOT_FIELDS-1:0][SLOT_W-1:0] slots;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  sle_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .in_cmd        (in_ch.cmd),
    .in_value      (in_ch.value),
    .in_line       (in_ch.line),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_read_data (out_ch.read_data),
    .out_hit_count (out_ch.hit_count),
    .out_overflow  (out_ch.overflow),
    .out_slots     (slots)
  );

  assign out_ch.slot_0 = slots[0];
  assign out_ch.slot_1 = slots[1];
  assign out_ch.slot_2 = slots[2];
  assign out_ch.slot_3 = slots[3];
  assign out_ch.slot_4 = slots[4];
  assign out_ch.slot_5 = slots[5];
  assign out_ch.slot_6 = slots[6];
  assign out_ch.slot_7 = slots[7];

endmodule

FILE: sv/sle_checker.sv
// port-level checks on the sprite line evaluation unit, bound to the top level
module sle_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sle_pkg::DATA_W-1:0] out_read_data,
  input logic [sle_pkg::HIT_W-1:0]  out_hit_count,
  input logic                       out_overflow,
  input logic [sle_pkg::SLOT_W-1:0] out_slot_0,
  input logic [sle_pkg::SLOT_W-1:0] out_slot_7
);
  import sle_pkg::*;

  logic ovf_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ovf_seen_r <= 1'b0;
    else if (out_valid && out_overflow) ovf_seen_r <= 1'b1;
  end

  // memory clear keeps commands out right after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("command taken during memory clear");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit_count)
      && $stable(out_read_data) && $stable(out_slot_0))
    else $error("stalled result beat changed");

  // overflow is sticky once reported
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ovf_seen_r |-> out_overflow)
    else $error("overflow flag cleared without reset");

  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_hit_count) <= MAX_PER_LINE)
    else $error("hit count above list depth");

  a_unused_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit_count < 4'd8 |-> out_slot_7 == '0)
    else $error("slot beyond hit count not cleared");

endmodule

bind sprite_line_evaluation_unit sle_checker u_sle_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_read_data (out_ch.read_data),
  .out_hit_count (out_ch.hit_count),
  .out_overflow  (out_ch.overflow),
  .out_slot_0    (out_ch.slot_0),
  .out_slot_7    (out_ch.slot_7)
);

FILE: dv/tb_sprite_line_evaluation_unit.sv
// testbench for the sprite line evaluation unit: directed and random commands, scoreboard check
module tb_sprite_line_evaluation_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sle_pkg::*;

  localparam bit [CMD_W-1:0] CMD_UNUSED_LO  = 3'd5;
  localparam bit [CMD_W-1:0] CMD_UNUSED_MID = 3'd6;
  localparam bit [CMD_W-1:0] CMD_UNUSED_HI  = 3'd7;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int END_SETTLE = 100;

  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic [HIT_W-1:0]  hit_count;
    logic              overflow;
    logic [SLOT_W-1:0] slot [SLOT_FIELDS];
  } line_result_t;

  class sprite_eval_scoreboard;
    bit [DATA_W-1:0] oam [MEM_BYTES];
    bit [ADDR_W-1:0] ptr;
    slot_t           found [SLOT_FIELDS];
    int unsigned     found_n;
    bit              ovf;
    bit              tall;
    line_result_t    expected_beats [$];
    int unsigned     errors, commands, results_checked;
    int unsigned     evals, evals_hit, evals_full, max_hits;

    function void note_command(bit [CMD_W-1:0] cmd, bit [DATA_W-1:0] value,
                               bit [DATA_W-1:0] line);
      line_result_t r;
      int unsigned  top, reach;
      int           e;
      r.read_data = '0;
      case (cmd)
        CMD_SET_PTR:  ptr = value;
        CMD_WRITE: begin
          oam[ptr] = value;
          ptr = ptr + 1'b1;
        end
        CMD_READ:     r.read_data = oam[ptr];
        CMD_READ_PTR: r.read_data = ptr;
        CMD_EVAL: begin
          reach = tall ? HEIGHT_TALL : HEIGHT_SHORT;
          found_n = 0;
          foreach (found[i]) found[i] = '0;
          for (e = 0; e < SPRITE_ENTRIES; e++) begin
            // top is one row below the stored y; kept wide so tall sprites never wrap
            top = oam[(e * 4) % MEM_BYTES] + 1;
            if (line < top || line > top + reach) continue;
            if (found_n >= MAX_PER_LINE) begin
              ovf = 1'b1;
              break;
            end
            found[found_n] = slot_t'(e);
            found_n++;
          end
          evals++;
          if (found_n > 0) evals_hit++;
          if (found_n == MAX_PER_LINE) evals_full++;
          if (found_n > max_hits) max_hits = found_n;
        end
        default: ;
      endcase
      r.hit_count = HIT_W'((found_n > HIT_MAX) ? HIT_MAX : found_n);
      r.overflow = ovf;
      foreach (r.slot[k]) r.slot[k] = (k < found_n) ? found[k] : '0;
      expected_beats = {expected_beats, r};
      commands++;
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(line_result_t got);
      line_result_t want;
      results_checked++;
      if (expected_beats.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      field_check("read_data", want.read_data, got.read_data);
      field_check("hit_count", want.hit_count, got.hit_count);
      field_check("overflow", want.overflow, got.overflow);
      foreach (want.slot[k]) field_check($sformatf("slot_%0d", k), want.slot[k], got.slot[k]);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  sle_in_if  in_ch ();
  sle_out_if out_ch ();

  sprite_line_evaluation_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  sprite_eval_scoreboard sb;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int unsigned beats_sent;
  int unsigned quiet_cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    line_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.read_data = out_ch.read_data;
      got.hit_count = out_ch.hit_count;
      got.overflow  = out_ch.overflow;
      got.slot[0] = out_ch.slot_0;
      got.slot[1] = out_ch.slot_1;
      got.slot[2] = out_ch.slot_2;
      got.slot[3] = out_ch.slot_3;
      got.slot[4] = out_ch.slot_4;
      got.slot[5] = out_ch.slot_5;
      got.slot[6] = out_ch.slot_6;
      got.slot[7] = out_ch.slot_7;
      sb.check_beat(got);
    end
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_command(in_ch.cmd, in_ch.value, in_ch.line);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_sprite_line_evaluation_unit: done, errors");
      $finish;
    end
  end

  function automatic bit [7:0] any_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic send_beat(input bit [CMD_W-1:0] cmd, input bit [7:0] value,
                           input bit [7:0] line);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.value <= value;
    in_ch.line  <= line;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  // hold the sender off until every command has produced its result beat
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.results_checked < beats_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_height(input bit tall);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= tall;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.tall = tall;
  endtask

  task automatic random_burst();
    int         pick, n, entry, reach;
    bit [7:0]   focus, y;
    pick = $urandom_range(99);
    reach = sb.tall ? HEIGHT_TALL : HEIGHT_SHORT;
    if (pick < 40) begin
      // place a cluster of sprites around one line, then evaluate it
      focus = any_byte();
      n = $urandom_range(1, 10);
      repeat (n) begin
        entry = $urandom_range(SPRITE_ENTRIES - 1);
        send_beat(CMD_SET_PTR, 8'(entry * 4), any_byte());
        if ($urandom_range(4) == 0) send_beat(CMD_READ, any_byte(), any_byte());
        y = ($urandom_range(3) == 0) ? any_byte() : focus - 8'd1 - 8'($urandom_range(reach));
        send_beat(CMD_WRITE, y, any_byte());
        if ($urandom_range(5) == 0) send_beat(CMD_READ_PTR, any_byte(), any_byte());
      end
      send_beat(CMD_EVAL, any_byte(), focus);
      if ($urandom_range(2) == 0) send_beat(CMD_EVAL, any_byte(), focus + 8'd1);
    end else if (pick < 55) begin
      send_beat(CMD_EVAL, any_byte(), any_byte());
    end else if (pick < 70) begin
      send_beat(CMD_WRITE, any_byte(), any_byte());
    end else if (pick < 78) begin
      send_beat(CMD_READ, any_byte(), any_byte());
    end else if (pick < 84) begin
      send_beat(CMD_READ_PTR, any_byte(), any_byte());
    end else if (pick < 92) begin
      send_beat(CMD_SET_PTR, any_byte(), any_byte());
    end else begin
      send_beat(3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO)), any_byte(), any_byte());
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit tall,
                           input int unsigned beats);
    int unsigned stop_at;
    set_height(tall);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) random_burst();
  endtask

  initial begin
    bit [7:0] cluster;
    sb = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_SET_PTR;
    in_ch.value = '0;
    in_ch.line = '0;
    out_ch.ready = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    beats_sent = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: cleared memory, unused commands, pointer wrap, bottom rows, overflow
    send_beat(CMD_READ, 8'h00, 8'h00);
    send_beat(CMD_READ_PTR, 8'hFF, 8'hFF);
    send_beat(CMD_UNUSED_LO, 8'hFF, 8'hFF);
    send_beat(CMD_UNUSED_MID, 8'h55, 8'hAA);
    send_beat(CMD_UNUSED_HI, 8'hAA, 8'h55);
    send_beat(CMD_EVAL, 8'h00, 8'd0);
    send_beat(CMD_SET_PTR, 8'hFF, 8'h00);
    send_beat(CMD_WRITE, 8'hAB, 8'h00);
    send_beat(CMD_READ_PTR, 8'h00, 8'h00);
    send_beat(CMD_SET_PTR, 8'hFF, 8'h00);
    send_beat(CMD_READ, 8'h00, 8'h00);
    send_beat(CMD_SET_PTR, 8'd0, 8'h00);
    send_beat(CMD_WRITE, 8'hFE, 8'h00);
    send_beat(CMD_SET_PTR, 8'd4, 8'h00);
    send_beat(CMD_WRITE, 8'hF0, 8'h00);
    send_beat(CMD_EVAL, 8'h00, 8'd255);
    send_beat(CMD_EVAL, 8'h00, 8'd248);
    send_beat(CMD_EVAL, 8'h00, 8'd249);
    set_height(1'b1);
    send_beat(CMD_EVAL, 8'h00, 8'd249);
    // tall sprite with y near the bottom must not wrap onto line 0
    send_beat(CMD_EVAL, 8'h00, 8'd0);
    send_beat(CMD_EVAL, 8'h00, 8'd16);
    send_beat(CMD_EVAL, 8'h00, 8'd17);
    set_height(1'b0);
    send_beat(CMD_EVAL, 8'h00, 8'd8);
    send_beat(CMD_READ_PTR, 8'h00, 8'h00);

    // load the whole memory, a third of the y bytes bunched around one line
    cluster = any_byte();
    send_beat(CMD_SET_PTR, 8'd0, any_byte());
    for (int i = 0; i < MEM_BYTES; i++) begin
      if (i % 4 == 0 && $urandom_range(2) == 0)
        send_beat(CMD_WRITE, cluster + 8'($urandom_range(12)), any_byte());
      else
        send_beat(CMD_WRITE, any_byte(), any_byte());
    end

    run_phase(0, 0, 1'b0, 200);
    run_phase(84, 0, 1'b1, 200);
    run_phase(0, 84, 1'b0, 200);
    run_phase(36, 36, 1'b1, 200);

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    $display("covered %0d commands and %0d line evaluations (%0d with hits, %0d at the cap)",
             sb.commands, sb.evals, sb.evals_hit, sb.evals_full);
    $display("both sprite heights, most hits on one line %0d, sticky overflow %0d",
             sb.max_hits, sb.ovf);
    if (sb.errors == 0) begin
      $display("tb_sprite_line_evaluation_unit: done, clean");
    end else begin
      $display("tb_sprite_line_evaluation_unit: done, errors");
    end
    $finish;
  end

endmodule
